@@ hdl/sbsa_pkg.sv @@
// Shared types and constants of the send buffer slot allocator.
`timescale 1ns / 1ps

package sbsa_pkg;

	localparam int SLOT_W  = 4;
	localparam int OP_W    = 8;
	localparam int TGT_W   = 12;
	localparam int BYTES_W = 24;
	localparam int SB_W    = 21;

	localparam logic [SB_W-1:0] SLOT_BYTES_RESET = 21'd4096;

	// cap on forced completions per item; the final status always follows
	localparam int MAX_FORCED = 4;

	localparam logic KIND_FORCED = 1'b0;
	localparam logic KIND_FINAL  = 1'b1;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_FENCE   = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STS_OK           = 3'd0,
		STS_BAD_INDEX    = 3'd1,
		STS_INCONSISTENT = 3'd2,
		STS_OUT_OF_RANGE = 3'd3,
		STS_TOO_LARGE    = 3'd4
	} status_t;

	// one slot of the ring as held in memory
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [TGT_W-1:0]  target;
		logic [SLOT_W-1:0] first;
		logic [SLOT_W-1:0] len;
	} entry_t;

	// one result transfer
	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] count;
		logic [OP_W-1:0]   op;
		logic [TGT_W-1:0]  target;
		status_t           status;
		logic              last;
	} res_t;

	// answer of the slot count unit
	typedef struct packed {
		logic              done;
		logic              too_large;
		logic [SLOT_W-1:0] count;
	} cnt_res_t;

endpackage

@@ hdl/send_buffer_slot_allocator.sv @@
// Top level of the send buffer slot allocator: slot memory and control sequencer.
`timescale 1ns / 1ps

// Usage
//   Issue a request by raising start with the payload while busy is low; it is
//   taken at that clock edge and busy rises for any work that follows. Results
//   leave on result_valid, one cycle each: zero or more forced completions
//   (kind 0) and then one final status with last set. The receiver cannot
//   stall; each result is taken in the cycle it is shown. slot_bytes is set via
//   cfg_wr_en / cfg_wr_data; the user keeps writes to idle, the block does not.
// Timing
//   The slot entries live in one RAM with registered read data, scanned one
//   entry a cycle with the read of the next entry overlapped. Release and
//   fence with a bad index, or the unused action, answer straight from idle.
//   Release looks the entry up and frees its set. Allocation waits for the k
//   add-and-compare steps of the slot count unit, k in 1..NUM_SLOTS, primes
//   the read and scans the c granted slots; fence scans all NUM_SLOTS slots.
//   The block accepts a new request in the cycle that shows the final status.
// Reset
//   Reset frees every slot (per-slot valid flags), clears the next-free
//   pointer and sets slot_bytes to 4096. No clearing pass is needed.

module send_buffer_slot_allocator #(
	parameter int NUM_SLOTS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_wr_en,
	input  logic [sbsa_pkg::SB_W-1:0]    cfg_wr_data,
	// request
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [sbsa_pkg::BYTES_W-1:0] request_bytes,
	input  logic [sbsa_pkg::OP_W-1:0]    op_code,
	input  logic [sbsa_pkg::TGT_W-1:0]   target,
	input  logic [sbsa_pkg::SLOT_W-1:0]  slot_index,
	input  logic [sbsa_pkg::TGT_W-1:0]   range_low,
	input  logic [sbsa_pkg::TGT_W-1:0]   range_high,
	// results
	output logic                         result_valid,
	output logic                         kind,
	output logic [sbsa_pkg::SLOT_W-1:0]  slot,
	output logic [sbsa_pkg::SLOT_W-1:0]  slot_count,
	output logic [sbsa_pkg::OP_W-1:0]    done_op,
	output logic [sbsa_pkg::TGT_W-1:0]   done_target,
	output logic [2:0]                   status,
	output logic                         last
);

	localparam int AW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ENTRY_W = $bits(sbsa_pkg::entry_t);
	localparam int SW      = sbsa_pkg::SLOT_W;
	localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS);
	localparam logic [2:0]    MAX_F     = 3'(sbsa_pkg::MAX_FORCED);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOOKUP,
		ST_REL,
		ST_FCHK,
		ST_PRIME,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t                       state_q;
	sbsa_pkg::action_t            act_q;
	logic [sbsa_pkg::OP_W-1:0]    opc_q;
	logic [sbsa_pkg::TGT_W-1:0]   tgt_q;
	logic [SW-1:0]                sidx_q;
	logic [sbsa_pkg::TGT_W-1:0]   lo_q;
	logic [sbsa_pkg::TGT_W-1:0]   hi_q;
	logic [SW-1:0]                idx_q;
	logic [SW-1:0]                end_q;
	logic [SW-1:0]                av_q;
	logic [SW-1:0]                cnt_q;
	logic [SW-1:0]                own_q;
	logic [SW-1:0]                nf_q;
	logic [2:0]                   n_q;
	logic [NUM_SLOTS-1:0]         valid_q;
	logic [sbsa_pkg::SB_W-1:0]    sb_q;
	sbsa_pkg::res_t               res_q;
	logic                         res_valid_q;

	sbsa_pkg::action_t            act_in;
	sbsa_pkg::cnt_res_t           cnt_res;
	logic                         cnt_start;
	logic [ENTRY_W-1:0]           ram_rdata;
	logic [ENTRY_W-1:0]           ram_wdata;
	logic                         ram_we;
	logic                         ram_re;
	logic [AW-1:0]                ram_raddr;
	sbsa_pkg::entry_t             rd_entry;
	sbsa_pkg::entry_t             ent;
	logic                         in_range;
	logic                         ent_busy;
	logic                         ent_first;
	logic                         mid_set_err;
	logic                         force_done;
	logic [SW:0]                  run_end;
	logic [NUM_SLOTS-1:0]         clr_mask;
	logic [NUM_SLOTS-1:0]         set_mask;
	logic [NUM_SLOTS-1:0]         valid_d;
	logic [SW-1:0]                nxt_idx;
	logic                         last_step;
	logic [SW-1:0]                base;
	logic [SW:0]                  base_sum;
	logic [SW-1:0]                av;
	logic [SW-1:0]                av_end;

	function automatic sbsa_pkg::res_t make_res(
		input logic                        k,
		input logic [SW-1:0]               s,
		input logic [SW-1:0]               c,
		input logic [sbsa_pkg::OP_W-1:0]   op,
		input logic [sbsa_pkg::TGT_W-1:0]  tg,
		input sbsa_pkg::status_t           st,
		input logic                        l
	);
		sbsa_pkg::res_t r;
		r.kind   = k;
		r.slot   = s;
		r.count  = c;
		r.op     = op;
		r.target = tg;
		r.status = st;
		r.last   = l;
		return r;
	endfunction

	assign busy   = (state_q != ST_IDLE);
	assign act_in = sbsa_pkg::action_t'(action);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_q <= sbsa_pkg::SLOT_BYTES_RESET;
		end else if (cfg_wr_en) begin
			sb_q <= cfg_wr_data;
		end
	end

	// slot count unit, started with each accepted allocation
	assign cnt_start = start && !busy && (act_in == sbsa_pkg::ACT_ALLOC);

	sbsa_cnt #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_cnt (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (cnt_start),
		.request_bytes(request_bytes),
		.slot_bytes   (sb_q),
		.res          (cnt_res)
	);

	// slot entry memory
	sbsa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// entry under work; a slot without its valid flag reads as free and zero
	assign rd_entry = sbsa_pkg::entry_t'(ram_rdata);
	assign ent      = valid_q[idx_q[AW-1:0]] ? rd_entry : '0;

	assign in_range  = (ent.target >= lo_q) && (ent.target <= hi_q);
	assign ent_busy  = (ent.op != '0);
	assign ent_first = (ent.first == idx_q);

	// start slot busy but not the head of its set
	assign mid_set_err = (act_q == sbsa_pkg::ACT_ALLOC) && (idx_q == av_q) &&
	                     ent_busy && !ent_first;

	// head of a busy set that must be completed now
	assign force_done = ent_busy && ent_first &&
	                    ((act_q == sbsa_pkg::ACT_ALLOC) || (in_range && (ent.first != own_q)));

	assign nxt_idx   = idx_q + SW'(1);
	assign last_step = (nxt_idx == end_q);
	assign run_end   = {1'b0, idx_q} + {1'b0, ent.len};

	// slots cleared by a completed set, and the slot being written
	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++) begin
			clr_mask[k] = ((SW+1)'(k) >= {1'b0, idx_q}) && ((SW+1)'(k) < run_end);
			set_mask[k] = (SW'(k) == idx_q);
		end
	end

	// next valid flags: clear first, then mark the slot written by an allocation
	always_comb begin
		valid_d = valid_q;
		if (state_q == ST_REL) begin
			valid_d = valid_q & ~clr_mask;
		end else if ((state_q == ST_SCAN) && !mid_set_err) begin
			if (force_done) begin
				valid_d = valid_q & ~clr_mask;
			end
			if (act_q == sbsa_pkg::ACT_ALLOC) begin
				valid_d = valid_d | set_mask;
			end
		end
	end

	// memory read and write control
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		if ((state_q == ST_LOOKUP) || (state_q == ST_PRIME)) begin
			ram_re = 1'b1;
		end else if (state_q == ST_SCAN) begin
			ram_re    = !last_step;
			ram_raddr = nxt_idx[AW-1:0];
		end
	end

	assign ram_we    = (state_q == ST_SCAN) && (act_q == sbsa_pkg::ACT_ALLOC) && !mid_set_err;
	assign ram_wdata = {opc_q, tgt_q, av_q, cnt_q};

	// placement of an allocation: wrap to slot zero if the run would pass the end
	assign base     = (nf_q < LAST_SLOT) ? nf_q : '0;
	assign base_sum = {1'b0, base} + {1'b0, cnt_res.count};
	assign av       = (base_sum > {1'b0, LAST_SLOT}) ? '0 : base;
	assign av_end   = av + cnt_res.count;

	// sequencer: state, slot bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			nf_q        <= '0;
			n_q         <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			valid_q     <= valid_d;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						act_q  <= act_in;
						opc_q  <= op_code;
						tgt_q  <= target;
						sidx_q <= slot_index;
						lo_q   <= range_low;
						hi_q   <= range_high;
						idx_q  <= slot_index;
						unique case (act_in)
							sbsa_pkg::ACT_ALLOC: begin
								state_q <= ST_DIV;
							end
							sbsa_pkg::ACT_RELEASE, sbsa_pkg::ACT_FENCE: begin
								if (slot_index >= LAST_SLOT) begin
									res_valid_q <= 1'b1;
									res_q <= make_res(sbsa_pkg::KIND_FINAL, '0, '0, '0, '0,
									                  sbsa_pkg::STS_BAD_INDEX, 1'b1);
								end else begin
									state_q <= ST_LOOKUP;
								end
							end
							sbsa_pkg::ACT_NONE: begin
								res_valid_q <= 1'b1;
								res_q <= make_res(sbsa_pkg::KIND_FINAL, '0, '0, '0, '0,
								                  sbsa_pkg::STS_OK, 1'b1);
							end
						endcase
					end
				end
				ST_DIV: begin
					if (cnt_res.done) begin
						if (cnt_res.too_large) begin
							res_valid_q <= 1'b1;
							res_q <= make_res(sbsa_pkg::KIND_FINAL, '0, '0, '0, '0,
							                  sbsa_pkg::STS_TOO_LARGE, 1'b1);
							state_q <= ST_IDLE;
						end else begin
							av_q    <= av;
							cnt_q   <= cnt_res.count;
							idx_q   <= av;
							end_q   <= av_end;
							n_q     <= '0;
							state_q <= ST_PRIME;
						end
					end
				end
				ST_LOOKUP: begin
					state_q <= (act_q == sbsa_pkg::ACT_RELEASE) ? ST_REL : ST_FCHK;
				end
				ST_REL: begin
					nf_q        <= idx_q;
					res_valid_q <= 1'b1;
					res_q <= make_res(sbsa_pkg::KIND_FINAL, idx_q, ent.len, ent.op, ent.target,
					                  sbsa_pkg::STS_OK, 1'b1);
					state_q <= ST_IDLE;
				end
				ST_FCHK: begin
					if (!in_range) begin
						res_valid_q <= 1'b1;
						res_q <= make_res(sbsa_pkg::KIND_FINAL, '0, '0, '0, '0,
						                  sbsa_pkg::STS_OUT_OF_RANGE, 1'b1);
						state_q <= ST_IDLE;
					end else begin
						own_q   <= ent.first;
						idx_q   <= '0;
						end_q   <= LAST_SLOT;
						n_q     <= '0;
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (mid_set_err) begin
						res_valid_q <= 1'b1;
						res_q <= make_res(sbsa_pkg::KIND_FINAL, '0, '0, '0, '0,
						                  sbsa_pkg::STS_INCONSISTENT, 1'b1);
						state_q <= ST_IDLE;
					end else begin
						// report a completed set while there is room
						if (force_done && (n_q < MAX_F)) begin
							res_valid_q <= 1'b1;
							res_q <= make_res(sbsa_pkg::KIND_FORCED, idx_q, ent.len, ent.op,
							                  ent.target, sbsa_pkg::STS_OK, 1'b0);
							n_q <= n_q + 3'd1;
						end
						if (last_step) begin
							if (act_q == sbsa_pkg::ACT_ALLOC) begin
								nf_q <= (end_q == LAST_SLOT) ? '0 : end_q;
							end
							state_q <= ST_FIN;
						end else begin
							idx_q <= nxt_idx;
						end
					end
				end
				ST_FIN: begin
					res_valid_q <= 1'b1;
					if (act_q == sbsa_pkg::ACT_ALLOC) begin
						res_q <= make_res(sbsa_pkg::KIND_FINAL, av_q, cnt_q, '0, '0,
						                  sbsa_pkg::STS_OK, 1'b1);
					end else begin
						res_q <= make_res(sbsa_pkg::KIND_FINAL, sidx_q, '0, '0, '0,
						                  sbsa_pkg::STS_OK, 1'b1);
					end
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign kind         = res_q.kind;
	assign slot         = res_q.slot;
	assign slot_count   = res_q.count;
	assign done_op      = res_q.op;
	assign done_target  = res_q.target;
	assign status       = res_q.status;
	assign last         = res_q.last;

	// leaving the busy phase always shows the final status
	a_final_on_exit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && last)
		else $error("busy dropped without a final status");

	// forced completions appear only while the request is still being worked
	a_forced_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == sbsa_pkg::KIND_FORCED) |-> busy && !last)
		else $error("forced completion outside the scan");

	// the slot count unit answers only to an allocation waiting for it
	a_cnt_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_res.done |-> state_q == ST_DIV)
		else $error("slot count answer outside the division wait");

	// the scan stays inside its run
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q < end_q)
		else $error("scan index past the end of the run");

	// the scan advances one slot a cycle
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && $past(state_q == ST_SCAN) |-> idx_q == $past(idx_q) + SW'(1))
		else $error("scan did not advance by one slot");

endmodule

@@ hdl/sbsa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sbsa_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/sbsa_cnt.sv @@
// Slot count unit: smallest k >= 1 with k * slot_bytes >= request_bytes.
`timescale 1ns / 1ps

module sbsa_cnt #(
	parameter int NUM_SLOTS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sbsa_pkg::BYTES_W-1:0]  request_bytes,
	input  logic [sbsa_pkg::SB_W-1:0]     slot_bytes,
	output sbsa_pkg::cnt_res_t            res
);

	localparam int ACC_W = sbsa_pkg::SB_W + sbsa_pkg::SLOT_W;
	localparam logic [sbsa_pkg::SLOT_W-1:0] LAST_K = sbsa_pkg::SLOT_W'(NUM_SLOTS);

	logic                         busy_q;
	logic [sbsa_pkg::BYTES_W-1:0] bytes_q;
	logic [ACC_W-1:0]             acc_q;
	logic [sbsa_pkg::SLOT_W-1:0]  k_q;
	sbsa_pkg::cnt_res_t           res_q;
	logic [sbsa_pkg::SB_W-1:0]    sb_eff;
	logic                         hit;

	// a zero slot size counts as one byte
	assign sb_eff = (slot_bytes == '0) ? sbsa_pkg::SB_W'(1) : slot_bytes;
	assign hit    = acc_q >= ACC_W'(bytes_q);

	// add one slot size per cycle until the running total covers the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			res_q  <= '0;
		end else begin
			res_q.done <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				bytes_q <= request_bytes;
				acc_q   <= ACC_W'(sb_eff);
				k_q     <= sbsa_pkg::SLOT_W'(1);
			end else if (busy_q) begin
				if (hit) begin
					busy_q          <= 1'b0;
					res_q.done      <= 1'b1;
					res_q.too_large <= 1'b0;
					res_q.count     <= k_q;
				end else if (k_q == LAST_K) begin
					busy_q          <= 1'b0;
					res_q.done      <= 1'b1;
					res_q.too_large <= 1'b1;
					res_q.count     <= '0;
				end else begin
					acc_q <= acc_q + ACC_W'(sb_eff);
					k_q   <= k_q + sbsa_pkg::SLOT_W'(1);
				end
			end
		end
	end

	assign res = res_q;

endmodule
